### src/vao_pkg.sv
// ----------------------------------------------------------------------------
// vao_pkg
// Shared types and constants for the oriented vector angle core.
// ----------------------------------------------------------------------------
package vao_pkg;

   localparam int MW           = 30;   // normalized magnitude width
   localparam int NW           = 64;   // square root remainder and root width
   localparam int XW           = 34;   // CORDIC x/y width
   localparam int ZW           = 46;   // CORDIC angle width, 2^-40 rad
   localparam int SQRT_STEPS   = 32;
   localparam int CORDIC_STEPS = 30;

   localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

   localparam logic signed [ZW-1:0] PI40     = ZW'((PI_Q62 + 64'd2097152) >> 22);
   localparam logic signed [ZW-1:0] HALF40   = ZW'((PI_Q62 + 64'd4194304) >> 23);
   localparam logic signed [ZW-1:0] TWO_PI40 = PI40 <<< 1;
   localparam logic signed [ZW-1:0] ROUND27  = ZW'(64'd67108864);
   localparam logic [15:0]          ANGLE_MAX = 16'd51472;

   typedef struct packed {
      logic zero;   // a or b is the zero vector
      logic flip;   // report 2*pi minus the angle
   } vao_tag_type;

   // atan(2^-i) in 2^-40 rad, series summed at 2^-62 then rounded
   function automatic logic [63:0] atan_q40(input int i);
      logic [63:0] acc;
      logic [63:0] term;
      acc = 64'd0;
      if (i == 0) begin
         acc = PI_Q62 >> 2;
      end else begin
         for (int k = 0; k < 32; k++) begin
            if (62 - i * (2 * k + 1) >= 0) begin
               term = (64'd1 << (62 - i * (2 * k + 1))) / 64'(2 * k + 1);
               if (k % 2 == 1) acc = acc - term;
               else acc = acc + term;
            end
         end
      end
      return (acc + 64'd2097152) >> 22;
   endfunction

endpackage

### src/vao_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vao_sqrt_cell
// One digit step of the restoring integer square root, registered.
// ----------------------------------------------------------------------------
module vao_sqrt_cell
   import vao_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic [NW-1:0]        in_rem,
   input  logic [NW-1:0]        in_root,
   input  logic signed [XW-1:0] in_x,
   input  vao_tag_type          in_tag,
   output logic                 out_valid,
   output logic [NW-1:0]        out_rem,
   output logic [NW-1:0]        out_root,
   output logic signed [XW-1:0] out_x,
   output vao_tag_type          out_tag
);

   localparam logic [NW-1:0] BIT = NW'(64'd1 << (62 - 2 * STEP));

   logic                 valid_ff;
   logic [NW-1:0]        rem_ff, rem_in;
   logic [NW-1:0]        root_ff, root_in;
   logic signed [XW-1:0] x_ff;
   vao_tag_type          tag_ff;
   logic [NW-1:0]        trial;

   always_comb begin
      trial = in_root + BIT;
      if (in_rem >= trial) begin
         rem_in  = in_rem - trial;
         root_in = (in_root >> 1) + BIT;
      end else begin
         rem_in  = in_rem;
         root_in = in_root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         x_ff    <= in_x;
         tag_ff  <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_x     = x_ff;
   assign out_tag   = tag_ff;

endmodule

### src/vao_cordic_cell.sv
// ----------------------------------------------------------------------------
// vao_cordic_cell
// One vectoring-mode CORDIC micro-rotation with angle accumulation.
// ----------------------------------------------------------------------------
module vao_cordic_cell
   import vao_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  logic signed [XW-1:0] in_x,
   input  logic signed [XW-1:0] in_y,
   input  logic signed [ZW-1:0] in_z,
   input  vao_tag_type          in_tag,
   output logic                 out_valid,
   output logic signed [XW-1:0] out_x,
   output logic signed [XW-1:0] out_y,
   output logic signed [ZW-1:0] out_z,
   output vao_tag_type          out_tag
);

   localparam logic signed [ZW-1:0] ATAN = ZW'(atan_q40(STEP));

   logic                 valid_ff;
   logic signed [XW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0] z_ff, z_in;
   vao_tag_type          tag_ff;
   logic signed [XW-1:0] dx, dy;

   always_comb begin
      dx = in_y >>> STEP;
      dy = in_x >>> STEP;
      if (in_y > 0) begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + ATAN;
      end else begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_tag   = tag_ff;

endmodule

### src/vector_angle_oriented_core.sv
// ----------------------------------------------------------------------------
// vector_angle_oriented_core
// Angle between two 3D vectors, optionally oriented about a plane normal.
// ----------------------------------------------------------------------------
// Takes one beat per cycle and returns one angle beat per input beat, in
// order, as unsigned Q3.13 radians (0 to 2*pi). The pipeline is made of the
// stages for products, triple product, block normalization and sum of squares,
// 32 square root cells, one quadrant stage, 30 CORDIC cells and the output
// register. When the output beat is not taken the whole pipeline holds.
module vector_angle_oriented_core
   import vao_pkg::*;
#(
   parameter int  COMPONENT_BITS = 16,
   localparam int W              = COMPONENT_BITS,
   localparam int REQ_BITS       = ((9 * W + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,  // ax, ay, az, bx, by, bz, nx, ny, nz
   input  logic                req_tuser,  // oriented mode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata   // angle
);

   localparam int VW = 2 * W + 2;
   localparam int CW = 2 * W + 1;
   localparam int TW = 3 * W + 4;
   localparam int LW = $clog2(VW + 1);

   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // stage 1: products
   logic signed [W-1:0]   a_in [3];
   logic signed [W-1:0]   b_in [3];
   logic signed [W-1:0]   n_in [3];
   logic                  v1_ff, zero1_ff, ori1_ff;
   logic signed [2*W-1:0] pab1_ff [3][3];
   logic signed [2*W-1:0] pbn1_ff [6];
   logic signed [W-1:0]   a1_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         a_in[k] = req_tdata[k*W +: W];
         b_in[k] = req_tdata[(k+3)*W +: W];
         n_in[k] = req_tdata[(k+6)*W +: W];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            a1_ff[i] <= a_in[i];
            for (int j = 0; j < 3; j++) begin
               pab1_ff[i][j] <= a_in[i] * b_in[j];
            end
         end
         pbn1_ff[0] <= b_in[1] * n_in[2];
         pbn1_ff[1] <= b_in[2] * n_in[1];
         pbn1_ff[2] <= b_in[2] * n_in[0];
         pbn1_ff[3] <= b_in[0] * n_in[2];
         pbn1_ff[4] <= b_in[0] * n_in[1];
         pbn1_ff[5] <= b_in[1] * n_in[0];
         zero1_ff   <= (a_in[0] == '0 && a_in[1] == '0 && a_in[2] == '0) ||
                       (b_in[0] == '0 && b_in[1] == '0 && b_in[2] == '0);
         ori1_ff    <= req_tuser;
      end
   end

   // stage 2: cross, dot and b x n
   logic                v2_ff, zero2_ff, ori2_ff;
   logic signed [VW-1:0] vec2_ff [4];
   logic signed [CW-1:0] c2_ff [3];
   logic signed [W-1:0]  a2_ff [3];

   always_ff @(posedge clock) begin
      if (advance) begin
         vec2_ff[0] <= VW'(pab1_ff[1][2]) - VW'(pab1_ff[2][1]);
         vec2_ff[1] <= VW'(pab1_ff[2][0]) - VW'(pab1_ff[0][2]);
         vec2_ff[2] <= VW'(pab1_ff[0][1]) - VW'(pab1_ff[1][0]);
         vec2_ff[3] <= VW'(pab1_ff[0][0]) + VW'(pab1_ff[1][1]) + VW'(pab1_ff[2][2]);
         c2_ff[0]   <= CW'(pbn1_ff[0]) - CW'(pbn1_ff[1]);
         c2_ff[1]   <= CW'(pbn1_ff[2]) - CW'(pbn1_ff[3]);
         c2_ff[2]   <= CW'(pbn1_ff[4]) - CW'(pbn1_ff[5]);
         a2_ff      <= a1_ff;
         zero2_ff   <= zero1_ff;
         ori2_ff    <= ori1_ff;
      end
   end

   // stage 3: triple product partials, magnitudes
   logic                 v3_ff, zero3_ff, ori3_ff, neg3_ff;
   logic signed [2*W:0]  pl3_ff [3];
   logic signed [2*W:0]  ph3_ff [3];
   logic [VW-1:0]        mag3_ff [4];

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            pl3_ff[k] <= a2_ff[k] * $signed({1'b0, c2_ff[k][W-1:0]});
            ph3_ff[k] <= a2_ff[k] * $signed(c2_ff[k][CW-1:W]);
         end
         for (int k = 0; k < 4; k++) begin
            mag3_ff[k] <= vec2_ff[k][VW-1] ? VW'(-vec2_ff[k]) : VW'(vec2_ff[k]);
         end
         neg3_ff  <= vec2_ff[3][VW-1];
         zero3_ff <= zero2_ff;
         ori3_ff  <= ori2_ff;
      end
   end

   // stage 4: triple product sign, block exponent
   logic                v4_ff, neg4_ff;
   vao_tag_type         tag4_ff;
   logic [LW-1:0]       len4_ff, len_in;
   logic [VW-1:0]       mag4_ff [4];
   logic [VW-1:0]       mag_or;
   logic signed [TW-1:0] tp;

   always_comb begin
      tp = (TW'(ph3_ff[0]) + TW'(ph3_ff[1]) + TW'(ph3_ff[2])) <<< W;
      tp = tp + TW'(pl3_ff[0]) + TW'(pl3_ff[1]) + TW'(pl3_ff[2]);
      mag_or = mag3_ff[0] | mag3_ff[1] | mag3_ff[2] | mag3_ff[3];
      len_in = '0;
      for (int k = 0; k < VW; k++) begin
         if (mag_or[k]) len_in = LW'(k + 1);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag4_ff.zero <= zero3_ff;
         tag4_ff.flip <= ori3_ff && (tp <= 0);
         len4_ff      <= len_in;
         mag4_ff      <= mag3_ff;
         neg4_ff      <= neg3_ff;
      end
   end

   // stage 5: block scale, largest magnitude to [2^29, 2^30)
   logic              v5_ff, neg5_ff;
   vao_tag_type       tag5_ff;
   logic [MW-1:0]     m5_ff [4];
   logic [MW-1:0]     m_in [4];
   logic [VW+MW-1:0]  ext [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ext[k] = {{MW{1'b0}}, mag4_ff[k]};
         if (len4_ff > LW'(MW)) begin
            m_in[k] = MW'(ext[k] >> (len4_ff - LW'(MW)));
         end else begin
            m_in[k] = MW'(ext[k] << (LW'(MW) - len4_ff));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m5_ff   <= m_in;
         neg5_ff <= neg4_ff;
         tag5_ff <= tag4_ff;
      end
   end

   // stage 6: squares
   logic                 v6_ff;
   vao_tag_type          tag6_ff;
   logic [2*MW-1:0]      sq6_ff [3];
   logic signed [XW-1:0] x6_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 3; k++) begin
            sq6_ff[k] <= m5_ff[k] * m5_ff[k];
         end
         x6_ff   <= neg5_ff ? -XW'(m5_ff[3]) : XW'(m5_ff[3]);
         tag6_ff <= tag5_ff;
      end
   end

   // stage 7: sum of squares
   logic                 v7_ff;
   vao_tag_type          tag7_ff;
   logic [NW-1:0]        n7_ff;
   logic signed [XW-1:0] x7_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         n7_ff   <= NW'(sq6_ff[0]) + NW'(sq6_ff[1]) + NW'(sq6_ff[2]);
         x7_ff   <= x6_ff;
         tag7_ff <= tag6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   // square root cells
   logic                 sq_valid [SQRT_STEPS+1];
   logic [NW-1:0]        sq_rem   [SQRT_STEPS+1];
   logic [NW-1:0]        sq_root  [SQRT_STEPS+1];
   logic signed [XW-1:0] sq_x     [SQRT_STEPS+1];
   vao_tag_type          sq_tag   [SQRT_STEPS+1];

   assign sq_valid[0] = v7_ff;
   assign sq_rem[0]   = n7_ff;
   assign sq_root[0]  = '0;
   assign sq_x[0]     = x7_ff;
   assign sq_tag[0]   = tag7_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
      vao_sqrt_cell #(.STEP(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (sq_valid[g]),
         .in_rem    (sq_rem[g]),
         .in_root   (sq_root[g]),
         .in_x      (sq_x[g]),
         .in_tag    (sq_tag[g]),
         .out_valid (sq_valid[g+1]),
         .out_rem   (sq_rem[g+1]),
         .out_root  (sq_root[g+1]),
         .out_x     (sq_x[g+1]),
         .out_tag   (sq_tag[g+1])
      );
   end

   // quadrant stage
   logic                 vr_ff;
   vao_tag_type          tagr_ff;
   logic signed [XW-1:0] xr_ff, yr_ff, ysq;
   logic signed [ZW-1:0] zr_ff;

   assign ysq = XW'(sq_root[SQRT_STEPS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         vr_ff <= 1'b0;
      end else if (advance) begin
         vr_ff <= sq_valid[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         if (sq_x[SQRT_STEPS] < 0) begin
            xr_ff <= ysq;
            yr_ff <= -sq_x[SQRT_STEPS];
            zr_ff <= HALF40;
         end else begin
            xr_ff <= sq_x[SQRT_STEPS];
            yr_ff <= ysq;
            zr_ff <= '0;
         end
         tagr_ff <= sq_tag[SQRT_STEPS];
      end
   end

   // CORDIC cells
   logic                 cr_valid [CORDIC_STEPS+1];
   logic signed [XW-1:0] cr_x     [CORDIC_STEPS+1];
   logic signed [XW-1:0] cr_y     [CORDIC_STEPS+1];
   logic signed [ZW-1:0] cr_z     [CORDIC_STEPS+1];
   vao_tag_type          cr_tag   [CORDIC_STEPS+1];

   assign cr_valid[0] = vr_ff;
   assign cr_x[0]     = xr_ff;
   assign cr_y[0]     = yr_ff;
   assign cr_z[0]     = zr_ff;
   assign cr_tag[0]   = tagr_ff;

   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
      vao_cordic_cell #(.STEP(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (cr_valid[g]),
         .in_x      (cr_x[g]),
         .in_y      (cr_y[g]),
         .in_z      (cr_z[g]),
         .in_tag    (cr_tag[g]),
         .out_valid (cr_valid[g+1]),
         .out_x     (cr_x[g+1]),
         .out_y     (cr_y[g+1]),
         .out_z     (cr_z[g+1]),
         .out_tag   (cr_tag[g+1])
      );
   end

   // output register
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_data_ff, rsp_data_in;
   logic signed [ZW-1:0] zf, qf;
   vao_tag_type          fin_tag;

   assign fin_tag = cr_tag[CORDIC_STEPS];

   always_comb begin
      zf = fin_tag.flip ? TWO_PI40 - cr_z[CORDIC_STEPS] : cr_z[CORDIC_STEPS];
      qf = (zf + ROUND27) >>> 27;
      if (fin_tag.zero || zf < 0) begin
         rsp_data_in = '0;
      end else if (qf > ZW'(ANGLE_MAX)) begin
         rsp_data_in = ANGLE_MAX;
      end else begin
         rsp_data_in = qf[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= cr_valid[CORDIC_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_angle_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= ANGLE_MAX)
      else $error("angle above 2*pi");

   a_zero_vector : assert property (@(posedge clock) disable iff (reset)
      advance && cr_valid[CORDIC_STEPS] && fin_tag.zero |=> rsp_tdata == '0)
      else $error("zero vector gave nonzero angle");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !v1_ff)
      else $error("valid after reset");

   a_no_flip_plain : assert property (@(posedge clock) disable iff (reset)
      advance && v3_ff && !ori3_ff |=> !tag4_ff.flip)
      else $error("flip set without oriented mode");

endmodule
